// ===== rtl/kmeans_plus_plus_seed_picker_unit_assert.svh =====
// Assertion macros used by the seed picker RTL.
`ifndef KMEANS_PLUS_PLUS_SEED_PICKER_UNIT_ASSERT_SVH
`define KMEANS_PLUS_PLUS_SEED_PICKER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/kpp_pkg.sv =====
package kpp_pkg;

  // Default sizes
  localparam int DEF_MAX_POINTS  = 1024;
  localparam int DEF_MAX_DIMS    = 16;
  localparam int DEF_MAX_CENTERS = 64;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int PIDX_W   = 10;
  localparam int DIDX_W   = 4;
  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int CNUM_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register widths and reset values
  localparam int NPTS_W = 11;
  localparam int NDIM_W = 5;
  localparam int NCLU_W = 7;
  localparam logic [NPTS_W-1:0] NPTS_RST = 11'd1024;
  localparam logic [NDIM_W-1:0] NDIM_RST = 5'd16;
  localparam logic [NCLU_W-1:0] NCLU_RST = 7'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd2;

  // Modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PICK  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

endpackage

// ===== rtl/kpp_channels.sv =====
interface kpp_in_if import kpp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PIDX_W-1:0]   point_index;
  logic [DIDX_W-1:0]   dim_index;
  logic signed [COORD_W-1:0] coord;
  logic [FRAC_W-1:0]   fraction;
  modport source (output valid, mode, point_index, dim_index, coord, fraction, input ready);
  modport sink (input valid, mode, point_index, dim_index, coord, fraction, output ready);
endinterface

interface kpp_out_if import kpp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIDX_W-1:0]   center_index;
  logic [CNUM_W-1:0]   center_number;
  logic [STATUS_W-1:0] status;
  modport source (output valid, center_index, center_number, status, input ready);
  modport sink (input valid, center_index, center_number, status, output ready);
endinterface

interface kpp_cfg_if import kpp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/kmeans_plus_plus_seed_picker_unit.sv =====
// Channel   Dir  Words
// in_ch     in   mode, point_index, dim_index, coord, fraction
// out_ch    out  center_index, center_number, status (one word per mode 1/2)
// cfg_ch    in   index, data
//
// Load words and mode 3 words are taken in the idle state. Mode 1 runs add_center, which
// walks every point and every coordinate through the point memory: S_RD, S_SQ and S_ACC per
// coordinate, S_UPD per point, then S_OUT. An accepted pick first forms the target product
// in S_MUL and scans points in S_SCAN_RD/S_SCAN_CMP before add_center. Error picks go to S_OUT.
// Synchronous active-low reset clears control and counts; memories are not cleared.
// A result word waits in the output register while the next input word is taken.
`include "kmeans_plus_plus_seed_picker_unit_assert.svh"
module kmeans_plus_plus_seed_picker_unit import kpp_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int MAX_CENTERS = DEF_MAX_CENTERS
) (
  input logic     clk,
  input logic     rst_n,
  kpp_in_if.sink  in_ch,
  kpp_out_if.source out_ch,
  kpp_cfg_if.sink cfg_ch
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int NPW    = $clog2(MAX_POINTS + 1);
  localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW     = $clog2(MAX_CENTERS + 1);
  localparam int AW     = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int PS_DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + $clog2(MAX_DIMS + 1);
  localparam int TOT_W  = DIST_W + $clog2(MAX_POINTS + 1);
  localparam int TGT_W  = TOT_W + FRAC_W;
  localparam int BW     = $clog2(FRAC_W);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SQ, S_ACC, S_UPD, S_MUL, S_SCAN_RD, S_SCAN_CMP, S_OUT
  } state_t;

  // Memories
  logic signed [COORD_W-1:0] ps_mem [PS_DEPTH];
  logic [DIST_W-1:0]         near_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] ps_qa_r, ps_qb_r;
  logic [DIST_W-1:0]         near_q_r;

  // Configuration registers
  logic [NPTS_W-1:0] num_points_r;
  logic [NDIM_W-1:0] num_dims_r;
  logic [NCLU_W-1:0] num_clusters_r;

  // Control and datapath registers
  state_t            state_r;
  logic [IW-1:0]     i_r, np_last_r, sel_r;
  logic [DW-1:0]     d_r, nd_last_r;
  logic [AW-1:0]     pt_base_r, ctr_base_r;
  logic              first_r, bump_r, mode1_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] acc_r;
  logic [TOT_W-1:0]  tot_acc_r, total_r, cum_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [FRAC_W-1:0] frac_r;
  logic [BW-1:0]     bit_r;
  logic [CW-1:0]     picked_r;
  logic [STATUS_W-1:0] status_r;
  logic              out_valid_r;
  logic [PIDX_W-1:0] out_index_r;
  logic [CNUM_W-1:0] out_number_r;
  logic [STATUS_W-1:0] out_status_r;

  // Clamped configuration
  logic [NPW-1:0] np_w;
  logic [IW-1:0]  np_last_w;
  logic [DW-1:0]  nd_last_w;
  logic [CW-1:0]  nc_w;
  logic [IW-1:0]  first_c_w;

  always_comb begin
    if (num_points_r == '0) np_w = NPW'(1);
    else if (32'(num_points_r) > 32'(MAX_POINTS)) np_w = NPW'(MAX_POINTS);
    else np_w = NPW'(num_points_r);
    np_last_w = IW'(np_w - NPW'(1));
    if (num_dims_r == '0) nd_last_w = '0;
    else if (32'(num_dims_r) > 32'(MAX_DIMS)) nd_last_w = DW'(MAX_DIMS - 1);
    else nd_last_w = DW'(num_dims_r - NDIM_W'(1));
    if (num_clusters_r == '0) nc_w = CW'(1);
    else if (32'(num_clusters_r) > 32'(MAX_CENTERS)) nc_w = CW'(MAX_CENTERS);
    else nc_w = CW'(num_clusters_r);
    first_c_w = (32'(in_ch.point_index) < 32'(np_w)) ? IW'(in_ch.point_index) : np_last_w;
  end

  // Handshake and load decode
  logic in_fire, load_we, out_free;
  logic [AW-1:0] load_addr;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign load_we      = in_fire && (in_ch.mode == MODE_LOAD)
                        && (32'(in_ch.point_index) < 32'(MAX_POINTS))
                        && (32'(in_ch.dim_index) < 32'(MAX_DIMS));
  assign load_addr    = AW'(32'(in_ch.point_index) * MAX_DIMS + 32'(in_ch.dim_index));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Datapath values
  logic signed [COORD_W:0] diff_w;
  logic [COORD_W-1:0]      mag_w;
  logic [DIST_W-1:0]       acc_nxt;
  logic [DIST_W-1:0]       new_dist_w;
  logic [TOT_W-1:0]        cum_nxt;

  always_comb begin
    diff_w     = (COORD_W+1)'(ps_qa_r) - (COORD_W+1)'(ps_qb_r);
    mag_w      = diff_w[COORD_W] ? COORD_W'(-diff_w) : COORD_W'(diff_w);
    acc_nxt    = acc_r + DIST_W'(sq_r);
    new_dist_w = (first_r || (acc_r < near_q_r)) ? acc_r : near_q_r;
    cum_nxt    = cum_r + TOT_W'(near_q_r);
  end

  // Point memory: write on load, two reads per coordinate step
  always_ff @(posedge clk) begin
    if (load_we) ps_mem[load_addr] <= in_ch.coord;
    ps_qa_r <= ps_mem[pt_base_r + AW'(d_r)];
    ps_qb_r <= ps_mem[ctr_base_r + AW'(d_r)];
  end

  // Nearest distance memory: read by point counter, write back on update
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) near_mem[i_r] <= new_dist_w;
    near_q_r <= near_mem[i_r];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r   <= NPTS_RST;
      num_dims_r     <= NDIM_RST;
      num_clusters_r <= NCLU_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_NUM_POINTS:   num_points_r   <= NPTS_W'(cfg_ch.data);
        REG_NUM_DIMS:     num_dims_r     <= NDIM_W'(cfg_ch.data);
        REG_NUM_CLUSTERS: num_clusters_r <= NCLU_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      picked_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      d_r         <= '0;
    end else begin
      // Load the output register from S_OUT, else drop the word once taken
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            np_last_r <= np_last_w;
            nd_last_r <= nd_last_w;
            i_r       <= '0;
            d_r       <= '0;
            pt_base_r <= '0;
            acc_r     <= '0;
            tot_acc_r <= '0;
            cum_r     <= '0;
            unique case (in_ch.mode)
              MODE_FIRST: begin
                sel_r      <= first_c_w;
                ctr_base_r <= AW'(32'(first_c_w) * MAX_DIMS);
                first_r    <= 1'b1;
                mode1_r    <= 1'b1;
                bump_r     <= 1'b1;
                status_r   <= ST_OK;
                state_r    <= S_RD;
              end
              MODE_PICK: begin
                mode1_r <= 1'b0;
                first_r <= 1'b0;
                sel_r   <= '0;
                if (picked_r >= nc_w) begin
                  bump_r   <= 1'b0;
                  status_r <= ST_EXHAUSTED;
                  state_r  <= S_OUT;
                end else if (total_r == '0) begin
                  bump_r   <= 1'b0;
                  status_r <= ST_ZERO;
                  state_r  <= S_OUT;
                end else begin
                  bump_r   <= 1'b1;
                  status_r <= ST_OK;
                  tgt_r    <= '0;
                  frac_r   <= in_ch.fraction;
                  bit_r    <= BW'(FRAC_W - 1);
                  state_r  <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        // Shift-add target = fraction * total, MSB first
        S_MUL: begin
          tgt_r  <= {tgt_r[TGT_W-2:0], 1'b0}
                    + (frac_r[FRAC_W-1] ? TGT_W'(total_r) : '0);
          frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
          bit_r  <= bit_r - BW'(1);
          if (bit_r == '0) state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        // Advance running sum; stop at first point that passes the target, else at the last point (selects point 0)
        S_SCAN_CMP: begin
          cum_r <= cum_nxt;
          if (({cum_nxt, {FRAC_W{1'b0}}} > tgt_r) || (i_r == np_last_r)) begin
            sel_r      <= ({cum_nxt, {FRAC_W{1'b0}}} > tgt_r) ? i_r : '0;
            ctr_base_r <= ({cum_nxt, {FRAC_W{1'b0}}} > tgt_r)
                          ? AW'(32'(i_r) * MAX_DIMS) : '0;
            i_r        <= '0;
            state_r    <= S_RD;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_RD: state_r <= S_SQ;
        S_SQ: begin
          sq_r    <= SQ_W'(mag_w) * SQ_W'(mag_w);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_nxt;
          if (d_r == nd_last_r) state_r <= S_UPD;
          else begin
            d_r     <= d_r + DW'(1);
            state_r <= S_RD;
          end
        end
        // Write back nearest distance and fold it into the total
        S_UPD: begin
          tot_acc_r <= tot_acc_r + TOT_W'(new_dist_w);
          acc_r     <= '0;
          d_r       <= '0;
          if (i_r == np_last_r) begin
            total_r <= tot_acc_r + TOT_W'(new_dist_w);
            state_r <= S_OUT;
          end else begin
            i_r       <= i_r + IW'(1);
            pt_base_r <= pt_base_r + AW'(MAX_DIMS);
            state_r   <= S_RD;
          end
        end
        // Hand the word to the output register
        S_OUT: begin
          if (out_free) begin
            out_index_r  <= PIDX_W'(sel_r);
            out_number_r <= (mode1_r || !bump_r) ? '0 : CNUM_W'(picked_r);
            out_status_r <= status_r;
            if (bump_r) picked_r <= mode1_r ? CW'(1) : picked_r + CW'(1);
            i_r     <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.center_index  = out_index_r;
  assign out_ch.center_number = out_number_r;
  assign out_ch.status        = out_status_r;

  `KPP_ASSERT(a_picked_bound, 32'(picked_r) <= 32'(MAX_CENTERS), "center count overflow")
  `KPP_ASSERT(a_scan_nonzero, (state_r == S_SCAN_CMP) |-> (total_r != '0), "scan with zero total")
  `KPP_ASSERT(a_dim_bound, (state_r == S_ACC) |-> (d_r <= nd_last_r), "coordinate index past end")
  `KPP_ASSERT(a_out_hold, (out_valid_r && !out_ch.ready) |=> out_valid_r, "result word dropped")
  `KPP_ASSERT(a_idle_ready, in_ch.ready == (state_r == S_IDLE), "ready outside idle")

endmodule
